### src/bitmap_id_allocator_defines.svh
// Assertion macros for the verification file of the allocator (bia_chk).
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH

// Checked only while reset is released.
`define BIA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bitmap_id_allocator: property violated");

// Checked on every edge, reset included.
`define BIA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bitmap_id_allocator: property violated during reset");

`endif

### src/bia_pkg.sv
package bia_pkg;

  localparam int WORD_W        = 32;
  localparam int BIT_W         = 5;
  localparam int POOL_SIZE_DEF = 4096;
  localparam int BASE_W        = 16;
  localparam int ID_W          = 17;
  localparam logic [BASE_W-1:0] BASE_RESET = 16'd300;

  typedef enum logic {
    OP_ALLOC,
    OP_RELEASE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### src/bia_map_ram.sv
module bia_map_ram #(
  parameter int DEPTH = bia_pkg::POOL_SIZE_DEF / bia_pkg::WORD_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [bia_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [bia_pkg::WORD_W-1:0] rdata
);

  logic [bia_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bia_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/bitmap_id_allocator.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_op, in_release_id
// out       output     out_valid / out_ready   out_status, out_granted_id
// cfg       input      cfg_valid / cfg_ready   cfg_base_id
//
// The in-use map sits in a RAM of 32-bit words. An allocate reads the words from
// word 0 upward until a free bit turns up (at most POOL_SIZE/32 words, rounded
// up); a release reads the word of its identifier, except one outside the pool.
// After reset a clearing pass writes one word a cycle, and no item is taken until
// it has cleared every word; cfg is always ready.
// While an earlier result waits for out_ready, the scan and the final step hold.
module bitmap_id_allocator #(
  parameter int POOL_SIZE = bia_pkg::POOL_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [bia_pkg::ID_W-1:0]    in_release_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [bia_pkg::ID_W-1:0]    out_granted_id,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bia_pkg::BASE_W-1:0]  cfg_base_id
);

  localparam int WORD_W    = bia_pkg::WORD_W;
  localparam int BIT_W     = bia_pkg::BIT_W;
  localparam int ID_W      = bia_pkg::ID_W;
  localparam int NUM_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LAST_WORD = NUM_WORDS - 1;
  localparam int TAIL      = POOL_SIZE - LAST_WORD * WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL);

  bia_pkg::state_t state_r, state_nxt;
  bia_pkg::op_t    op_r, op_nxt;
  logic [ID_W-1:0]             rid_r, rid_nxt;
  logic [bia_pkg::BASE_W-1:0]  base_r, base_nxt;
  logic [WA_W-1:0]             chk_r, chk_nxt;
  logic [WA_W-1:0]             clr_r, clr_nxt;

  logic                   out_valid_r, out_valid_nxt;
  bia_pkg::status_t       out_status_r, out_status_nxt;
  logic [ID_W-1:0]        out_id_r, out_id_nxt;

  logic                   ram_we;
  logic [WA_W-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]      ram_wdata, ram_rdata;

  logic                   out_free;
  logic                   emit;
  logic [ID_W:0]          diff;
  logic                   out_of_range;
  logic [WA_W-1:0]        rel_word;
  logic [BIT_W-1:0]       rel_bit;
  logic [WORD_W-1:0]      vmask;
  logic [WORD_W-1:0]      free_w;
  logic                   any_free;
  logic [BIT_W-1:0]       free_bit;
  logic                   chk_last;
  logic                   in_xfer;

  assign in_ready  = (state_r == bia_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Slot offset of the identifier to release; a borrow means it lies below base.
  assign diff         = {1'b0, rid_r} - {2'b0, base_r};
  assign out_of_range = diff[ID_W] || (diff[ID_W-1:0] >= ID_W'(POOL_SIZE));
  assign rel_word     = diff[BIT_W +: WA_W];
  assign rel_bit      = diff[BIT_W-1:0];

  assign chk_last = (chk_r == WA_W'(LAST_WORD));
  assign vmask    = chk_last ? TAIL_MASK : {WORD_W{1'b1}};
  assign free_w   = ~ram_rdata & vmask;
  assign any_free = |free_w;
  assign free_bit = bia_pkg::lowest_set(free_w);

  bia_map_ram #(
    .DEPTH (NUM_WORDS),
    .AW    (WA_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bia_pkg::S_CLEAR: begin
        if (clr_r == WA_W'(LAST_WORD)) begin
          state_nxt = bia_pkg::S_IDLE;
        end
      end
      bia_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = bia_pkg::S_READ;
        end
      end
      bia_pkg::S_READ: begin
        if (op_r == bia_pkg::OP_RELEASE && out_of_range) begin
          if (out_free) begin
            state_nxt = bia_pkg::S_IDLE;
          end
        end else begin
          state_nxt = bia_pkg::S_SCAN;
        end
      end
      bia_pkg::S_SCAN: begin
        if (out_free && (op_r == bia_pkg::OP_RELEASE || any_free || chk_last)) begin
          state_nxt = bia_pkg::S_IDLE;
        end
      end
      default: state_nxt = bia_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_nxt         = op_r;
    rid_nxt        = rid_r;
    chk_nxt        = chk_r;
    clr_nxt        = clr_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = chk_r;
    emit           = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    base_nxt       = cfg_valid ? cfg_base_id : base_r;

    unique case (state_r)
      bia_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + WA_W'(1);
      end
      bia_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_nxt  = bia_pkg::op_t'(in_op);
          rid_nxt = in_release_id;
        end
      end
      bia_pkg::S_READ: begin
        if (op_r == bia_pkg::OP_RELEASE) begin
          if (out_of_range) begin
            if (out_free) begin
              emit           = 1'b1;
              out_status_nxt = bia_pkg::ST_RANGE;
              out_id_nxt     = '0;
            end
          end else begin
            ram_raddr = rel_word;
            chk_nxt   = rel_word;
          end
        end else begin
          ram_raddr = '0;
          chk_nxt   = '0;
        end
      end
      bia_pkg::S_SCAN: begin
        // While the result slot is busy the current word is simply read again.
        if (out_free) begin
          if (op_r == bia_pkg::OP_RELEASE) begin
            emit = 1'b1;
            out_id_nxt = '0;
            if (ram_rdata[rel_bit]) begin
              ram_we         = 1'b1;
              ram_wdata      = ram_rdata & ~(WORD_W'(1) << rel_bit);
              out_status_nxt = bia_pkg::ST_OK;
            end else begin
              out_status_nxt = bia_pkg::ST_FREE;
            end
          end else if (any_free) begin
            emit           = 1'b1;
            ram_we         = 1'b1;
            ram_wdata      = ram_rdata | (WORD_W'(1) << free_bit);
            out_status_nxt = bia_pkg::ST_OK;
            out_id_nxt     = ID_W'(base_r) + ID_W'({chk_r, free_bit});
          end else if (chk_last) begin
            emit           = 1'b1;
            out_status_nxt = bia_pkg::ST_EMPTY;
            out_id_nxt     = '0;
          end else begin
            ram_raddr = chk_r + WA_W'(1);
            chk_nxt   = chk_r + WA_W'(1);
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bia_pkg::S_CLEAR;
      clr_r       <= '0;
      chk_r       <= '0;
      op_r        <= bia_pkg::OP_ALLOC;
      base_r      <= bia_pkg::BASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      chk_r       <= chk_nxt;
      op_r        <= op_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rid_r        <= rid_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_granted_id = out_id_r;

endmodule

### src/bia_chk.sv
`include "bitmap_id_allocator_defines.svh"

module bia_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_op,
  input logic [bia_pkg::ID_W-1:0]    in_release_id,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [bia_pkg::ID_W-1:0]    out_granted_id,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [bia_pkg::BASE_W-1:0]  cfg_base_id
);

  // Only a successful allocate carries an identifier.
  `BIA_ASSERT(a_id_only_on_ok, out_valid && (out_status != bia_pkg::ST_OK) |-> out_granted_id == '0)

  // A result that is not taken stays as it is.
  `BIA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_granted_id))

  // One request at a time: after a transfer in, the input side closes.
  `BIA_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)

  // Reset leaves no result pending and the map clear still to come.
  `BIA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !in_ready && !out_valid)

endmodule

bind bitmap_id_allocator bia_chk u_bia_chk (.*);
